// ===== rtl/isa_pkg.sv =====
// ----------------------------------------------------------------------------
// isa_pkg
// Shared types and constants of the instance slot allocator: request and
// result payloads, operation and status codes, controller command set.
// ----------------------------------------------------------------------------
package isa_pkg;

  // fixed field widths
  localparam int IDX_W  = 10;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  // parameter defaults
  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_WORD_BITS = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_SET   = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  // request payload
  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] slot_index;
    logic             enable_value;
  } in_req_t;

  // result payload
  typedef struct packed {
    logic [IDX_W-1:0]  result_index;
    logic              bit_value;
    logic [STAT_W-1:0] status;
  } out_res_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic pop_rd;
    logic div_en;
    logic bm_rd;
    logic commit;
    logic clr_wr;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

// ===== rtl/isa_ctrl.sv =====
// ----------------------------------------------------------------------------
// isa_ctrl
// Sequencing state machine: bitmap clearing pass after reset, then one
// request at a time through stack read, word address, bitmap read, commit.
// ----------------------------------------------------------------------------
module isa_ctrl
  import isa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_POP  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: if (start) state_nxt = ST_POP;
      ST_POP:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_WR;
      ST_WR:   state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.load_req = (state_r == ST_IDLE) && start;
    cmd.pop_rd   = (state_r == ST_POP);
    cmd.div_en   = (state_r == ST_DIV);
    cmd.bm_rd    = (state_r == ST_RD);
    cmd.commit   = (state_r == ST_WR);
    cmd.clr_wr   = (state_r == ST_CLR);
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/isa_dp.sv =====
// ----------------------------------------------------------------------------
// isa_dp
// Allocator datapath: free stack memory, depth and high-water counters,
// enable bitmap memory with word/bit split, tracking register and result
// register.
// ----------------------------------------------------------------------------
module isa_dp
  import isa_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_t     cmd,
  output sts_t     sts,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  input  in_req_t  in_req,
  output logic     out_strobe,
  output out_res_t out_res
);

  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int DEPTH_W   = SLOT_W + 1;
  localparam int TGT_W     = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
  localparam int NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int DIV_K     = SLOT_W + BIT_W;
  localparam int RECIP_W   = SLOT_W + 1;
  localparam int PROD_W    = SLOT_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << DIV_K) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_L);
  localparam logic [TGT_W:0]     CAP_T  = (TGT_W + 1)'(CAPACITY);
  localparam logic [DEPTH_W-1:0] CAP_D  = DEPTH_W'(CAPACITY);
  localparam logic [SLOT_W-1:0]  WB_S   = SLOT_W'(WORD_BITS);
  localparam logic [WADDR_W-1:0] LAST_W = WADDR_W'(NUM_WORDS - 1);

  // storage
  logic [IDX_W-1:0]     stack_mem [CAPACITY];
  logic [WORD_BITS-1:0] bm_mem    [NUM_WORDS];

  logic                 track_r;
  in_req_t              req_r;
  logic [IDX_W-1:0]     stack_q_r;
  logic [DEPTH_W-1:0]   depth_r;
  logic [DEPTH_W-1:0]   depth_nxt;
  logic [DEPTH_W-1:0]   hw_r;
  logic [DEPTH_W-1:0]   hw_nxt;
  logic [WADDR_W-1:0]   clr_cnt_r;
  logic [TGT_W-1:0]     tgt_r;
  logic [TGT_W-1:0]     tgt_nxt;
  logic                 in_rng_r;
  logic                 full_r;
  logic                 full_nxt;
  logic                 pop_r;
  logic                 pop_nxt;
  logic [WADDR_W-1:0]   q_r;
  logic [WADDR_W-1:0]   q_nxt;
  logic [PROD_W-1:0]    prod;
  logic [SLOT_W-1:0]    rem;
  logic [BIT_W-1:0]     rem_r;
  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_mod;
  logic                 out_strobe_r;
  out_res_t             out_res_r;
  out_res_t             res_nxt;
  logic                 bm_we;
  logic                 bv;
  logic                 push;
  logic                 dec;
  logic                 inc_hw;

  // tracking register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= 1'b1;
    end else if (cfg_wr_en) begin
      track_r <= cfg_wr_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_req;
    end
  end

  // target slot selection and word address by reciprocal multiply
  always_comb begin
    pop_nxt  = (req_r.operation == OP_ALLOC) && (depth_r != '0);
    full_nxt = (req_r.operation == OP_ALLOC) && (depth_r == '0) && (hw_r == CAP_D);
    if (req_r.operation == OP_ALLOC) begin
      tgt_nxt = pop_nxt ? TGT_W'(stack_q_r) : TGT_W'(hw_r);
    end else begin
      tgt_nxt = TGT_W'(req_r.slot_index);
    end
    prod  = PROD_W'(tgt_nxt[SLOT_W-1:0]) * PROD_W'(RECIP);
    q_nxt = WADDR_W'(prod >> DIV_K);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_en) begin
      tgt_r    <= tgt_nxt;
      in_rng_r <= ({1'b0, tgt_nxt} < CAP_T);
      full_r   <= full_nxt;
      pop_r    <= pop_nxt;
      q_r      <= q_nxt;
    end
  end

  // bit offset within the word
  assign rem = tgt_r[SLOT_W-1:0] - SLOT_W'(SLOT_W'(q_r) * WB_S);

  always_ff @(posedge clk) begin
    if (cmd.bm_rd) begin
      rem_r <= BIT_W'(rem);
    end
  end

  // operation decode at commit
  always_comb begin
    res_nxt.result_index = req_r.slot_index;
    res_nxt.bit_value    = 1'b0;
    res_nxt.status       = STAT_OK;
    bm_we                = 1'b0;
    bv                   = 1'b0;
    push                 = 1'b0;
    dec                  = 1'b0;
    inc_hw               = 1'b0;
    unique case (req_r.operation)
      OP_ALLOC: begin
        if (full_r) begin
          res_nxt.result_index = '0;
          res_nxt.status       = STAT_FULL;
        end else begin
          res_nxt.result_index = tgt_r[IDX_W-1:0];
          bm_we                = track_r && in_rng_r;
          bv                   = 1'b1;
          dec                  = pop_r;
          inc_hw               = !pop_r;
        end
      end
      OP_FREE: begin
        if (in_rng_r) begin
          bm_we = track_r;
          if (depth_r < CAP_D) begin
            push = 1'b1;
          end else begin
            res_nxt.status = STAT_OVERFLOW;
          end
        end
      end
      OP_SET: begin
        bm_we = track_r && in_rng_r;
        bv    = req_r.enable_value;
      end
      OP_QUERY: begin
        res_nxt.bit_value = track_r && in_rng_r && word_r[rem_r];
      end
    endcase
  end

  // read-modify-write of the bitmap word
  always_comb begin
    word_mod        = word_r;
    word_mod[rem_r] = bv;
  end

  // counters
  always_comb begin
    depth_nxt = depth_r;
    hw_nxt    = hw_r;
    if (cmd.commit) begin
      if (push) depth_nxt = depth_r + 1'b1;
      if (dec) depth_nxt = depth_r - 1'b1;
      if (inc_hw) hw_nxt = hw_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      hw_r    <= '0;
    end else begin
      depth_r <= depth_nxt;
      hw_r    <= hw_nxt;
    end
  end

  // free stack memory
  always_ff @(posedge clk) begin
    if (cmd.commit && push) begin
      stack_mem[depth_r[SLOT_W-1:0]] <= req_r.slot_index;
    end
    if (cmd.pop_rd) begin
      stack_q_r <= stack_mem[SLOT_W'(depth_r - 1'b1)];
    end
  end

  // bitmap memory: clearing pass or commit write, registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      bm_mem[clr_cnt_r] <= '0;
    end else if (cmd.commit && bm_we) begin
      bm_mem[q_r] <= word_mod;
    end
    if (cmd.bm_rd) begin
      word_r <= bm_mem[q_r];
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr && (clr_cnt_r != LAST_W)) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clr_last = (clr_cnt_r == LAST_W);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

// ===== rtl/instance_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// instance_slot_allocator
// Slot allocator with a LIFO free stack, a high-water counter and a
// per-slot enable bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on in_req and transfer at a rising edge where start is
//   high and busy is low. Operations: allocate, free, set enable bit, query
//   enable bit. Each request gives exactly one result on out_res, shown for
//   one cycle with out_strobe high; the receiver cannot stall it.
//   Sequence: a request passes through stack read, word address multiply,
//   bitmap read and bitmap write-back, each through a single-port memory or
//   a registered multiplier. The result strobe goes high and busy drops in
//   the same cycle; no new request is taken before busy has dropped.
//   Configuration: cfg_wr_en/cfg_wr_data write the tracking enable; write
//   it only while the block is idle.
//   Reset: rst_n (synchronous, active low) empties the free stack, zeroes
//   the high-water counter, sets tracking on, then runs a clearing pass over
//   the ceil(CAPACITY / WORD_BITS) bitmap words (32 at the defaults), with
//   busy high, before the first request is taken.
// ----------------------------------------------------------------------------
module instance_slot_allocator
  import isa_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_strobe,
  output out_res_t out_res,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  // controller
  isa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath
  isa_dp #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_req      (in_req),
    .out_strobe  (out_strobe),
    .out_res     (out_res)
  );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the instance slot allocator. A queue of requests
// (a short directed run, then phases of random traffic, with tracking on
// and off, a sweep that uses up every slot and a sweep that overfills the
// free stack) feeds a clocked driver with random idle gaps. An in-bench
// model of the free stack, high-water counter and enable bitmap predicts
// each result, and a clocked monitor compares it field by field.
// ----------------------------------------------------------------------------
module tb_top
  import isa_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP        = DEF_CAPACITY;
  localparam int IDLE_LIMIT = 500;

  logic     clk         = 1'b0;
  logic     rst_n       = 1'b0;
  logic     start       = 1'b0;
  logic     busy;
  in_req_t  in_req      = '0;
  logic     out_strobe;
  out_res_t out_res;
  logic     cfg_wr_en   = 1'b0;
  logic     cfg_wr_data = 1'b1;

  // allocator model state
  logic [IDX_W-1:0] freed_slots [CAP];
  int               stack_depth = 0;
  int               fresh_next  = 0;
  bit [CAP-1:0]     slot_bits   = '0;
  bit               track_on    = 1'b1;

  in_req_t  pending_reqs[$];
  out_res_t results_due[$];
  out_res_t want_res;
  int       gap_left    = 0;
  int       calm_left   = 0;
  int       idle_cycles = 0;
  int       fail_count  = 0;

  instance_slot_allocator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_strobe  (out_strobe),
    .out_res     (out_res),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected result of one request, updating the model
  function automatic out_res_t predict_result(in_req_t r);
    out_res_t res;
    res.result_index = r.slot_index;
    res.bit_value    = 1'b0;
    res.status       = STAT_OK;
    case (r.operation)
      OP_ALLOC: begin
        // reuse the most recently freed slot, else a fresh one
        if (stack_depth > 0) begin
          stack_depth--;
          res.result_index = freed_slots[stack_depth];
        end else if (fresh_next < CAP) begin
          res.result_index = IDX_W'(fresh_next);
          fresh_next++;
        end else begin
          res.result_index = '0;
          res.status       = STAT_FULL;
        end
        if (res.status == STAT_OK && track_on)
          slot_bits[res.result_index] = 1'b1;
      end
      OP_FREE: begin
        // bit is cleared even when the push is dropped
        if (track_on)
          slot_bits[r.slot_index] = 1'b0;
        if (stack_depth < CAP) begin
          freed_slots[stack_depth] = r.slot_index;
          stack_depth++;
        end else begin
          res.status = STAT_OVERFLOW;
        end
      end
      OP_SET: begin
        if (track_on)
          slot_bits[r.slot_index] = r.enable_value;
      end
      default: begin
        res.bit_value = track_on & slot_bits[r.slot_index];
      end
    endcase
    return res;
  endfunction

  // idle cycles before the next request, with runs of back-to-back traffic
  function automatic int draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic void add_req(logic [OP_W-1:0] op, logic [IDX_W-1:0] slot, logic val);
    in_req_t r;
    r.operation    = op;
    r.slot_index   = slot;
    r.enable_value = val;
    pending_reqs.push_back(r);
  endfunction

  // random request, weights in percent, query takes the rest
  function automatic void add_random(int alloc_pct, int free_pct, int set_pct);
    int               pick;
    logic [OP_W-1:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct)
      op = OP_ALLOC;
    else if (pick < alloc_pct + free_pct)
      op = OP_FREE;
    else if (pick < alloc_pct + free_pct + set_pct)
      op = OP_SET;
    else
      op = OP_QUERY;
    add_req(op, IDX_W'($urandom_range(0, CAP - 1)), 1'($urandom_range(0, 1)));
  endfunction

  // wait until every request has transferred and every result has come
  task automatic settle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || results_due.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_tracking(bit v);
    settle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    track_on = v;
    @(negedge clk);
  endtask

  // driver: one request per transfer, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!(start && busy)) begin
      if (start) begin
        results_due.push_back(predict_result(in_req));
        gap_left = draw_gap();
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_req <= pending_reqs.pop_front();
        start  <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: result_index %0d", out_res.result_index);
        fail_count++;
      end else begin
        want_res = results_due.pop_front();
        if (out_res.result_index !== want_res.result_index) begin
          $error("result_index: expected %0d, got %0d",
                 want_res.result_index, out_res.result_index);
          fail_count++;
        end
        if (out_res.bit_value !== want_res.bit_value) begin
          $error("bit_value: expected %0d, got %0d", want_res.bit_value, out_res.bit_value);
          fail_count++;
        end
        if (out_res.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, out_res.status);
          fail_count++;
        end
      end
    end
    // watchdog on cycles with no transfer either way
    if ((start && busy === 1'b0) || out_strobe === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // let the bitmap clearing pass finish
    repeat (2) @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    set_tracking(1'b1);

    // directed: reset bitmap, fresh and reused slots, set and query extremes
    add_req(OP_QUERY, 10'd0,    1'b1);
    add_req(OP_QUERY, 10'd1023, 1'b0);
    add_req(OP_ALLOC, 10'd1023, 1'b1);
    add_req(OP_ALLOC, 10'd0,    1'b0);
    add_req(OP_ALLOC, 10'd682,  1'b1);
    add_req(OP_QUERY, 10'd1,    1'b0);
    add_req(OP_SET,   10'd1023, 1'b1);
    add_req(OP_QUERY, 10'd1023, 1'b0);
    add_req(OP_SET,   10'd1023, 1'b0);
    add_req(OP_QUERY, 10'd1023, 1'b1);
    add_req(OP_SET,   10'd0,    1'b0);
    add_req(OP_QUERY, 10'd0,    1'b0);
    add_req(OP_FREE,  10'd1,    1'b1);
    add_req(OP_QUERY, 10'd1,    1'b0);
    add_req(OP_FREE,  10'd2,    1'b0);
    add_req(OP_ALLOC, 10'd0,    1'b0);
    add_req(OP_ALLOC, 10'd0,    1'b0);
    add_req(OP_ALLOC, 10'd0,    1'b0);
    add_req(OP_FREE,  10'd1023, 1'b1);
    add_req(OP_ALLOC, 10'd341,  1'b0);
    add_req(OP_QUERY, 10'd1023, 1'b0);
    add_req(OP_SET,   10'd682,  1'b1);
    add_req(OP_QUERY, 10'd682,  1'b0);
    add_req(OP_SET,   10'd341,  1'b1);
    add_req(OP_QUERY, 10'd341,  1'b1);

    // tracking off: stack and counter still move, bitmap frozen
    set_tracking(1'b0);
    repeat (200) add_random(25, 25, 25);

    // use up every slot, then a few allocations past the end
    set_tracking(1'b1);
    settle();
    n = stack_depth + (CAP - fresh_next) + 6;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_random(0, 0, 50);
      add_req(OP_ALLOC, IDX_W'($urandom_range(0, CAP - 1)), 1'($urandom_range(0, 1)));
    end

    // fill the free stack, then a few frees onto a full stack
    settle();
    n = (CAP - stack_depth) + 6;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_random(0, 0, 50);
      add_req(OP_FREE, IDX_W'($urandom_range(0, CAP - 1)), 1'($urandom_range(0, 1)));
    end

    // mixed traffic from a full stack, both tracking settings
    set_tracking(1'b0);
    repeat (100) add_random(30, 30, 20);
    set_tracking(1'b1);
    repeat (300) add_random(30, 30, 20);

    settle();
    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
